// ===== sv/matrix_row_transform_4x4_top_assert.svh =====
// assertion macros for the row transform block
`ifndef MATRIX_ROW_TRANSFORM_4X4_TOP_ASSERT_SVH
`define MATRIX_ROW_TRANSFORM_4X4_TOP_ASSERT_SVH

// same-cycle implication
`define MRT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mrt assertion failed");

// next-cycle implication
`define MRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mrt assertion failed");

`endif

// ===== sv/mrt_pkg.sv =====
package mrt_pkg;

  localparam int NFIELDS   = 4;
  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 4;
  localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_MUL  = 1'b1;

  typedef logic signed [31:0] word_t;
  typedef logic [OCNT_W-1:0] ocount_t;

  localparam word_t WORD_MAX = 32'sh7fff_ffff;
  localparam word_t WORD_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    KIND_NOP,
    KIND_LOAD,
    KIND_MUL
  } kind_t;

  typedef struct packed {
    kind_t                    kind;
    logic [1:0]               row_sel;
    logic [1:0]               col_sel;
    word_t                    load_value;
    word_t [NFIELDS-1:0]      vec;
  } cmd_t;

  typedef struct packed {
    word_t [NFIELDS-1:0]      res;
    logic                     saturated;
  } result_t;

endpackage

// ===== sv/mrt_front.sv =====
module mrt_front #(
  parameter int DIM = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic          operation,
  input  logic [1:0]    row_sel,
  input  logic [1:0]    col_sel,
  input  mrt_pkg::word_t load_value,
  input  mrt_pkg::word_t vec_0,
  input  mrt_pkg::word_t vec_1,
  input  mrt_pkg::word_t vec_2,
  input  mrt_pkg::word_t vec_3,
  output logic          cmd_valid,
  input  logic          cmd_take,
  output mrt_pkg::cmd_t cmd
);
  import mrt_pkg::*;

  localparam int PW = $clog2(CMD_DEPTH);
  localparam int CW = $clog2(CMD_DEPTH + 1);
  localparam logic [3:0] DIM_W = 4'(DIM);

  cmd_t          q [CMD_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  cmd_t          in_cmd;
  logic          enq;
  logic          deq;

  // classify: out-of-range loads are dropped here
  always_comb begin
    in_cmd.row_sel    = row_sel;
    in_cmd.col_sel    = col_sel;
    in_cmd.load_value = load_value;
    in_cmd.vec        = {vec_3, vec_2, vec_1, vec_0};
    if (operation == OP_MUL) begin
      in_cmd.kind = KIND_MUL;
    end else if (({2'b00, row_sel} < DIM_W) && ({2'b00, col_sel} < DIM_W)) begin
      in_cmd.kind = KIND_LOAD;
    end else begin
      in_cmd.kind = KIND_NOP;
    end
  end

  assign full      = (count == CW'(CMD_DEPTH));
  assign enq       = push && !full && (in_cmd.kind != KIND_NOP);
  assign deq       = cmd_take;
  assign cmd_valid = (count != '0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (deq) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      case ({enq, deq})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q[wr_ptr] <= in_cmd;
    end
  end

endmodule

// ===== sv/mrt_back.sv =====
module mrt_back #(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_take,
  input  mrt_pkg::cmd_t    cmd,
  input  mrt_pkg::ocount_t out_level,
  output logic             res_push,
  output mrt_pkg::result_t res
);
  import mrt_pkg::*;

  localparam int NE = (DIM < NFIELDS) ? DIM : NFIELDS;
  localparam logic [31:0] DIAG = 32'(1) << FRAC_BITS;

  word_t               mat  [NE][NE];
  logic signed [63:0]  prod [NE][NE];
  logic signed [65:0]  acc  [NE];
  logic signed [65:0]  acc_next [NE];
  word_t               vec_w [NFIELDS];
  logic                v1;
  logic                v2;
  logic [OCNT_W:0]     used;
  logic                credit_ok;
  logic                issue_mul;
  logic                do_load;

  // results still in flight plus those queued must leave room
  assign used      = {1'b0, out_level} + (OCNT_W+1)'(v1) + (OCNT_W+1)'(v2);
  assign credit_ok = used < (OCNT_W+1)'(OUT_DEPTH);
  assign cmd_take  = cmd_valid && ((cmd.kind != KIND_MUL) || credit_ok);
  assign issue_mul = cmd_take && (cmd.kind == KIND_MUL);
  assign do_load   = cmd_take && (cmd.kind == KIND_LOAD);

  always_comb begin
    for (int k = 0; k < NFIELDS; k++) begin
      vec_w[k] = cmd.vec[k];
    end
  end

  // matrix store, identity after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NE; r++) begin
        for (int c = 0; c < NE; c++) begin
          mat[r][c] <= (r == c) ? DIAG : '0;
        end
      end
    end else if (do_load) begin
      for (int r = 0; r < NE; r++) begin
        for (int c = 0; c < NE; c++) begin
          if ((cmd.row_sel == 2'(r)) && (cmd.col_sel == 2'(c))) begin
            mat[r][c] <= cmd.load_value;
          end
        end
      end
    end
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    if (issue_mul) begin
      for (int k = 0; k < NE; k++) begin
        for (int j = 0; j < NE; j++) begin
          prod[k][j] <= 64'(vec_w[k]) * 64'(mat[k][j]);
        end
      end
    end
  end

  // stage 2: shifted column sums
  always_comb begin
    for (int j = 0; j < NE; j++) begin
      acc_next[j] = '0;
      for (int k = 0; k < NE; k++) begin
        acc_next[j] = acc_next[j] + 66'(prod[k][j] >>> FRAC_BITS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      for (int j = 0; j < NE; j++) begin
        acc[j] <= acc_next[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= issue_mul;
      v2 <= v1;
    end
  end

  // saturate into the result queue
  always_comb begin
    res.saturated = 1'b0;
    for (int j = 0; j < NFIELDS; j++) begin
      res.res[j] = '0;
    end
    for (int j = 0; j < NE; j++) begin
      if ((&acc[j][65:31]) || !(|acc[j][65:31])) begin
        res.res[j] = acc[j][31:0];
      end else begin
        res.res[j]    = acc[j][65] ? WORD_MIN : WORD_MAX;
        res.saturated = 1'b1;
      end
    end
  end

  assign res_push = v2;

endmodule

// ===== sv/mrt_outq.sv =====
module mrt_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_push,
  input  mrt_pkg::result_t din,
  output mrt_pkg::ocount_t level,
  output logic             empty,
  input  logic             pop,
  output mrt_pkg::result_t dout
);
  import mrt_pkg::*;

  localparam int PW = $clog2(OUT_DEPTH);

  result_t       q [OUT_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  ocount_t       count;
  logic          deq;

  assign empty = (count == '0);
  assign deq   = pop && !empty;
  assign level = count;
  assign dout  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (res_push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (deq) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      case ({res_push, deq})
        2'b10:   count <= count + OCNT_W'(1);
        2'b01:   count <= count - OCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      q[wr_ptr] <= din;
    end
  end

endmodule

// ===== sv/matrix_row_transform_4x4_top.sv =====
// a multiply item passes the product and sum registers, then the result queue
// one item per cycle while the queue has room, set by one multiplier per element and a
// two-stage multiply/sum pipeline; loads complete in the back end and give no result
// reset (rst, synchronous): queues empty, matrix returns to identity
module matrix_row_transform_4x4_top #(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  logic           operation,
  input  logic [1:0]     row_sel,
  input  logic [1:0]     col_sel,
  input  mrt_pkg::word_t load_value,
  input  mrt_pkg::word_t vec_0,
  input  mrt_pkg::word_t vec_1,
  input  mrt_pkg::word_t vec_2,
  input  mrt_pkg::word_t vec_3,
  output logic           empty,
  input  logic           pop,
  output mrt_pkg::word_t res_0,
  output mrt_pkg::word_t res_1,
  output mrt_pkg::word_t res_2,
  output mrt_pkg::word_t res_3,
  output logic           saturated
);
  import mrt_pkg::*;

  cmd_t    cmd;
  logic    cmd_valid;
  logic    cmd_take;
  result_t res;
  logic    res_push;
  ocount_t out_level;
  result_t head;

  mrt_front #(
    .DIM (DIM)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .operation  (operation),
    .row_sel    (row_sel),
    .col_sel    (col_sel),
    .load_value (load_value),
    .vec_0      (vec_0),
    .vec_1      (vec_1),
    .vec_2      (vec_2),
    .vec_3      (vec_3),
    .cmd_valid  (cmd_valid),
    .cmd_take   (cmd_take),
    .cmd        (cmd)
  );

  mrt_back #(
    .DIM       (DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd),
    .out_level (out_level),
    .res_push  (res_push),
    .res       (res)
  );

  mrt_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .din      (res),
    .level    (out_level),
    .empty    (empty),
    .pop      (pop),
    .dout     (head)
  );

  assign res_0     = head.res[0];
  assign res_1     = head.res[1];
  assign res_2     = head.res[2];
  assign res_3     = head.res[3];
  assign saturated = head.saturated;

endmodule

// ===== sv/mrt_checker.sv =====
`include "matrix_row_transform_4x4_top_assert.svh"

module mrt_checker (
  input logic           clk,
  input logic           rst,
  input logic           full,
  input logic           empty,
  input logic           pop,
  input mrt_pkg::word_t res_0,
  input mrt_pkg::word_t res_1,
  input mrt_pkg::word_t res_2,
  input mrt_pkg::word_t res_3,
  input logic           saturated
);
  import mrt_pkg::*;

  logic [128:0] head_bits;
  logic         at_rail;

  assign head_bits = {res_3, res_2, res_1, res_0, saturated};
  assign at_rail   = (res_0 == WORD_MAX) || (res_0 == WORD_MIN) ||
                     (res_1 == WORD_MAX) || (res_1 == WORD_MIN) ||
                     (res_2 == WORD_MAX) || (res_2 == WORD_MIN) ||
                     (res_3 == WORD_MAX) || (res_3 == WORD_MIN);

  // queues come out of reset empty
  `MRT_ASSERT_NOW(a_reset_idle, $past(rst), empty && !full)

  `MRT_ASSERT_NEXT(a_hold_result, !empty && !pop, !empty && $stable(head_bits))

  // a clipped result shows at least one element at a rail
  `MRT_ASSERT_NOW(a_sat_rail, !empty && saturated, at_rail)

endmodule

bind matrix_row_transform_4x4_top mrt_checker u_mrt_checker (.*);
